### hw/rtl/mi3_pkg.sv
// Shared types, widths and index tables for the 3x3 matrix inverse block.
package mi3_pkg;

   localparam int unsigned ELEM_W    = 32;
   localparam int unsigned FRAC_W    = 16;
   localparam int unsigned NUM_ELEMS = 9;
   localparam int unsigned PROD_W    = 2 * ELEM_W;
   localparam int unsigned ADJ_W     = PROD_W + 1;
   localparam int unsigned DET_W     = ELEM_W + ADJ_W;
   localparam int unsigned NMAG_W    = PROD_W;
   localparam int unsigned DMAG_W    = DET_W - 1;
   localparam int unsigned REM_W     = DET_W;
   localparam int unsigned DIV_STEPS = 2 * FRAC_W;
   localparam int unsigned STEP_CNT_W = $clog2(DIV_STEPS + 1);
   localparam int unsigned FRONT_STAGES = 4;
   localparam int unsigned FRONT_CNT_W = $clog2(FRONT_STAGES + 1);

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ADJ_W-1:0]  adj_type;
   typedef logic signed [DET_W-1:0]  det_type;

   // Each cofactor is m[a]*m[b] - m[c]*m[d], with the indices in this order.
   localparam int unsigned COF_IDX [NUM_ELEMS][4] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
   };

   // Expansion along the first row: det = sum of m[k] * adj[DET_ADJ[k]].
   localparam int unsigned DET_ADJ [3] = '{0, 3, 6};

   typedef struct packed {
      logic busy;
      logic done;
   } front_status_type;

   typedef struct packed {
      logic [NUM_ELEMS-1:0][ELEM_W-1:0] elems;
      logic                             singular;
      logic                             overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_RUN  = 3'b010,
      B_DONE = 3'b100
   } back_state_type;

endpackage

### hw/rtl/matrix_inverse_3x3.sv
// Top level of the 3x3 fixed-point matrix inverse by the adjugate.
// The accepted matrix passes the cofactor and determinant pipeline, then the
// divider lanes, then the output registers that drive rsp_valid and the result.
// When fed continuously, the 32-step divider lanes limit the rate of matrices,
// and the cofactor pipeline overlaps them.
// Reset clears the pipeline control; no result is pending after reset.
// The receiver cannot stall: each result is shown for one cycle only.
module matrix_inverse_3x3 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_in_r0c0,
   input  logic [31:0] req_in_r0c1,
   input  logic [31:0] req_in_r0c2,
   input  logic [31:0] req_in_r1c0,
   input  logic [31:0] req_in_r1c1,
   input  logic [31:0] req_in_r1c2,
   input  logic [31:0] req_in_r2c0,
   input  logic [31:0] req_in_r2c1,
   input  logic [31:0] req_in_r2c2,
   output logic        rsp_valid,
   output logic [31:0] rsp_out_r0c0,
   output logic [31:0] rsp_out_r0c1,
   output logic [31:0] rsp_out_r0c2,
   output logic [31:0] rsp_out_r1c0,
   output logic [31:0] rsp_out_r1c1,
   output logic [31:0] rsp_out_r1c2,
   output logic [31:0] rsp_out_r2c0,
   output logic [31:0] rsp_out_r2c1,
   output logic [31:0] rsp_out_r2c2,
   output logic        rsp_singular,
   output logic        rsp_overflow
);

   logic                              accept;
   logic                              take;
   mi3_pkg::elem_type                 m_in [mi3_pkg::NUM_ELEMS];
   mi3_pkg::adj_type                  adj [mi3_pkg::NUM_ELEMS];
   mi3_pkg::det_type                  det;
   mi3_pkg::front_status_type         front_st;

   mi3_pkg::back_state_type           bstate_ff;
   mi3_pkg::back_state_type           bstate_in;
   logic [mi3_pkg::STEP_CNT_W-1:0]    bcnt_ff;
   logic [mi3_pkg::STEP_CNT_W-1:0]    bcnt_in;
   logic                              sing_ff;
   logic                              step;

   logic [mi3_pkg::NUM_ELEMS-1:0][mi3_pkg::ELEM_W-1:0] lane_result;
   logic [mi3_pkg::NUM_ELEMS-1:0]                      lane_sat;
   mi3_pkg::rsp_type                                  merged;
   mi3_pkg::rsp_type                                  rsp_ff;
   logic                                              rsp_valid_ff;

   // A transfer is taken whenever the cofactor stage is free. That stage
   // empties as soon as the divider lanes pick up its matrix, so a new
   // matrix enters while the previous one is still being divided.
   assign accept = start && !busy;
   assign busy   = front_st.busy;

   assign m_in[0] = req_in_r0c0;
   assign m_in[1] = req_in_r0c1;
   assign m_in[2] = req_in_r0c2;
   assign m_in[3] = req_in_r1c0;
   assign m_in[4] = req_in_r1c1;
   assign m_in[5] = req_in_r1c2;
   assign m_in[6] = req_in_r2c0;
   assign m_in[7] = req_in_r2c1;
   assign m_in[8] = req_in_r2c2;

   mi3_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .take    (take),
      .m_in    (m_in),
      .adj_out (adj),
      .det_out (det),
      .status  (front_st)
   );

   // The lanes load a finished matrix only while they are idle.
   assign take = front_st.done && (bstate_ff == mi3_pkg::B_IDLE);
   assign step = (bstate_ff == mi3_pkg::B_RUN);

   always_comb begin
      bstate_in = bstate_ff;
      bcnt_in   = bcnt_ff;
      unique case (bstate_ff)
         mi3_pkg::B_IDLE: begin
            if (take) begin
               bstate_in = mi3_pkg::B_RUN;
               bcnt_in   = '0;
            end
         end
         mi3_pkg::B_RUN: begin
            bcnt_in = bcnt_ff + 1'b1;
            if (bcnt_ff == mi3_pkg::STEP_CNT_W'(mi3_pkg::DIV_STEPS - 1)) begin
               bstate_in = mi3_pkg::B_DONE;
            end
         end
         mi3_pkg::B_DONE: begin
            bstate_in = mi3_pkg::B_IDLE;
         end
         default: begin
            bstate_in = mi3_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff    <= mi3_pkg::B_IDLE;
         bcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bstate_ff    <= bstate_in;
         bcnt_ff      <= bcnt_in;
         rsp_valid_ff <= (bstate_ff == mi3_pkg::B_DONE);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sing_ff <= (det == '0);
      end
      if (bstate_ff == mi3_pkg::B_DONE) begin
         rsp_ff <= merged;
      end
   end

   for (genvar k = 0; k < mi3_pkg::NUM_ELEMS; k++) begin : g_lane
      mi3_lane u_lane (
         .clock  (clock),
         .load   (take),
         .step   (step),
         .adj_in (adj[k]),
         .det_in (det),
         .result (lane_result[k]),
         .sat    (lane_sat[k])
      );
   end

   mi3_merge u_merge (
      .lane_result (lane_result),
      .lane_sat    (lane_sat),
      .singular    (sing_ff),
      .rsp         (merged)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_r0c0 = rsp_ff.elems[0];
   assign rsp_out_r0c1 = rsp_ff.elems[1];
   assign rsp_out_r0c2 = rsp_ff.elems[2];
   assign rsp_out_r1c0 = rsp_ff.elems[3];
   assign rsp_out_r1c1 = rsp_ff.elems[4];
   assign rsp_out_r1c2 = rsp_ff.elems[5];
   assign rsp_out_r2c0 = rsp_ff.elems[6];
   assign rsp_out_r2c1 = rsp_ff.elems[7];
   assign rsp_out_r2c2 = rsp_ff.elems[8];
   assign rsp_singular = rsp_ff.singular;
   assign rsp_overflow = rsp_ff.overflow;

endmodule

### hw/rtl/mi3_front.sv
// Cofactor and determinant pipeline: products, cofactors, split products, sum.
module mi3_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       take,
   input  mi3_pkg::elem_type          m_in [mi3_pkg::NUM_ELEMS],
   output mi3_pkg::adj_type           adj_out [mi3_pkg::NUM_ELEMS],
   output mi3_pkg::det_type           det_out,
   output mi3_pkg::front_status_type  status
);

   logic                                fv_ff;
   logic [mi3_pkg::FRONT_CNT_W-1:0]     cnt_ff;
   mi3_pkg::elem_type                   m_ff [mi3_pkg::NUM_ELEMS];
   mi3_pkg::prod_type                   p_ff [2*mi3_pkg::NUM_ELEMS];
   mi3_pkg::adj_type                    adj_ff [mi3_pkg::NUM_ELEMS];
   mi3_pkg::adj_type                    dlo_ff [3];
   mi3_pkg::adj_type                    dhi_ff [3];
   mi3_pkg::det_type                    det_ff;
   mi3_pkg::det_type                    det_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff  <= 1'b0;
         cnt_ff <= '0;
      end else if (accept) begin
         fv_ff  <= 1'b1;
         cnt_ff <= '0;
      end else if (take) begin
         fv_ff  <= 1'b0;
      end else if (fv_ff && (cnt_ff != mi3_pkg::FRONT_CNT_W'(mi3_pkg::FRONT_STAGES))) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         m_ff <= m_in;
      end
   end

   // All stages recompute each cycle; the matrix holds still until the next
   // transfer, so every stage is consistent by the time done is raised.
   for (genvar k = 0; k < mi3_pkg::NUM_ELEMS; k++) begin : g_cof
      always_ff @(posedge clock) begin
         p_ff[2*k]   <= m_ff[mi3_pkg::COF_IDX[k][0]] * m_ff[mi3_pkg::COF_IDX[k][1]];
         p_ff[2*k+1] <= m_ff[mi3_pkg::COF_IDX[k][2]] * m_ff[mi3_pkg::COF_IDX[k][3]];
         adj_ff[k]   <= mi3_pkg::ADJ_W'(p_ff[2*k]) - mi3_pkg::ADJ_W'(p_ff[2*k+1]);
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_det
      always_ff @(posedge clock) begin
         dlo_ff[r] <= m_ff[r] *
                      $signed({1'b0, adj_ff[mi3_pkg::DET_ADJ[r]][mi3_pkg::ELEM_W-1:0]});
         dhi_ff[r] <= m_ff[r] *
                      $signed(adj_ff[mi3_pkg::DET_ADJ[r]][mi3_pkg::ADJ_W-1:mi3_pkg::ELEM_W]);
      end
   end

   always_comb begin
      det_in = '0;
      for (int r = 0; r < 3; r++) begin
         det_in = det_in + (mi3_pkg::DET_W'(dhi_ff[r]) <<< mi3_pkg::ELEM_W)
                         + mi3_pkg::DET_W'(dlo_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      det_ff <= det_in;
   end

   assign adj_out     = adj_ff;
   assign det_out     = det_ff;
   assign status.busy = fv_ff;
   assign status.done = fv_ff && (cnt_ff == mi3_pkg::FRONT_CNT_W'(mi3_pkg::FRONT_STAGES));

endmodule

### hw/rtl/mi3_lane.sv
// One restoring divider lane: cofactor over determinant, saturated result.
module mi3_lane (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          step,
   input  mi3_pkg::adj_type              adj_in,
   input  mi3_pkg::det_type              det_in,
   output logic [mi3_pkg::ELEM_W-1:0]    result,
   output logic                          sat
);

   logic [mi3_pkg::NMAG_W-1:0]  nmag;
   logic [mi3_pkg::DMAG_W-1:0]  dmag;
   logic [mi3_pkg::ADJ_W-1:0]   nabs;
   logic [mi3_pkg::DET_W-1:0]   dabs;
   logic [mi3_pkg::REM_W-1:0]   rem_ff;
   logic [mi3_pkg::DMAG_W-1:0]  den_ff;
   logic [mi3_pkg::ELEM_W-1:0]  q_ff;
   logic                        big_ff;
   logic                        neg_ff;
   logic [mi3_pkg::REM_W-1:0]   r2;
   logic                        ge;
   logic [mi3_pkg::ELEM_W-1:0]  lim;

   assign nabs = adj_in[mi3_pkg::ADJ_W-1] ? -adj_in : adj_in;
   assign dabs = det_in[mi3_pkg::DET_W-1] ? -det_in : det_in;
   assign nmag = nabs[mi3_pkg::NMAG_W-1:0];
   assign dmag = dabs[mi3_pkg::DMAG_W-1:0];

   assign r2 = {rem_ff[mi3_pkg::REM_W-2:0], 1'b0};
   assign ge = r2 >= {1'b0, den_ff};

   // A quotient of 2^32 or more appears exactly when |adj| >= |det|; otherwise
   // the remainder starts below the divisor and 32 steps give the quotient.
   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= mi3_pkg::REM_W'(nmag);
         den_ff <= dmag;
         q_ff   <= '0;
         big_ff <= mi3_pkg::DMAG_W'(nmag) >= dmag;
         neg_ff <= adj_in[mi3_pkg::ADJ_W-1] ^ det_in[mi3_pkg::DET_W-1];
      end else if (step) begin
         rem_ff <= ge ? (r2 - mi3_pkg::REM_W'(den_ff)) : r2;
         q_ff   <= {q_ff[mi3_pkg::ELEM_W-2:0], ge};
      end
   end

   assign lim = {1'b1, {(mi3_pkg::ELEM_W-1){1'b0}}};

   always_comb begin
      if (!neg_ff) begin
         sat    = big_ff || q_ff[mi3_pkg::ELEM_W-1];
         result = sat ? (lim - 1'b1) : q_ff;
      end else begin
         sat    = big_ff || (q_ff > lim);
         result = sat ? lim : (-q_ff);
      end
   end

endmodule

### hw/rtl/mi3_merge.sv
// Merging stage: gathers the lane results and forms the item's flags.
module mi3_merge (
   input  logic [mi3_pkg::NUM_ELEMS-1:0][mi3_pkg::ELEM_W-1:0] lane_result,
   input  logic [mi3_pkg::NUM_ELEMS-1:0]                      lane_sat,
   input  logic                                              singular,
   output mi3_pkg::rsp_type                                  rsp
);

   always_comb begin
      if (singular) begin
         rsp.elems    = '0;
         rsp.singular = 1'b1;
         rsp.overflow = 1'b0;
      end else begin
         rsp.elems    = lane_result;
         rsp.singular = 1'b0;
         rsp.overflow = |lane_sat;
      end
   end

endmodule

### hw/rtl/mi3_checker.sv
// Port-level checker for the matrix inverse block, bound to the top level.
module mi3_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        rsp_valid,
   input  logic [31:0] rsp_out_r0c0,
   input  logic [31:0] rsp_out_r1c1,
   input  logic [31:0] rsp_out_r2c2,
   input  logic        rsp_singular,
   input  logic        rsp_overflow
);

   // Results are separated by the divider run, never on adjacent cycles.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes on adjacent cycles");

   // A taken transfer occupies the input stage for the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after a transfer");

   // A singular matrix never reports saturation.
   a_sing_no_ovf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> !rsp_overflow)
      else $error("singular and overflow both set");

   // A singular matrix yields a zero diagonal.
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |->
         (rsp_out_r0c0 == '0 && rsp_out_r1c1 == '0 && rsp_out_r2c2 == '0))
      else $error("singular result with nonzero elements");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_out_r0c0 (rsp_out_r0c0),
   .rsp_out_r1c1 (rsp_out_r1c1),
   .rsp_out_r2c2 (rsp_out_r2c2),
   .rsp_singular (rsp_singular),
   .rsp_overflow (rsp_overflow)
);

### dv/matrix_inverse_3x3_test.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse block.
`timescale 1ns / 1ps

module matrix_inverse_3x3_test;
   import mi3_pkg::*;

   // One inverse as the block reports it: nine Q16.16 elements and two flags.
   typedef struct packed {
      logic [NUM_ELEMS-1:0][ELEM_W-1:0] elems;
      logic                             singular;
      logic                             overflow;
   } inverse_type;

   typedef logic [NUM_ELEMS-1:0][ELEM_W-1:0] matrix_type;

   // A directed row: the matrix, and where it is obvious, the inverse typed in.
   typedef struct {
      matrix_type  mat;
      logic        typed;
      inverse_type inv;
   } stim_row_type;

   localparam int unsigned ITEMS      = 1400;
   localparam int unsigned LIMIT      = 400000;
   localparam int unsigned DRAIN      = 60;
   localparam logic [31:0] ONE        = 32'h0001_0000;
   localparam logic [31:0] POS_MAX    = 32'h7fff_ffff;
   localparam logic [31:0] NEG_MAX    = 32'h8000_0000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   matrix_type  req_mat = '0;
   logic        req_typed = 1'b0;
   inverse_type req_inv = '0;
   logic        rsp_valid;
   matrix_type  rsp_mat;
   logic        rsp_singular;
   logic        rsp_overflow;

   inverse_type expected_inverses[$];
   int unsigned failures = 0;
   int unsigned cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   matrix_inverse_3x3 i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_in_r0c0  (req_mat[0]),
      .req_in_r0c1  (req_mat[1]),
      .req_in_r0c2  (req_mat[2]),
      .req_in_r1c0  (req_mat[3]),
      .req_in_r1c1  (req_mat[4]),
      .req_in_r1c2  (req_mat[5]),
      .req_in_r2c0  (req_mat[6]),
      .req_in_r2c1  (req_mat[7]),
      .req_in_r2c2  (req_mat[8]),
      .rsp_valid    (rsp_valid),
      .rsp_out_r0c0 (rsp_mat[0]),
      .rsp_out_r0c1 (rsp_mat[1]),
      .rsp_out_r0c2 (rsp_mat[2]),
      .rsp_out_r1c0 (rsp_mat[3]),
      .rsp_out_r1c1 (rsp_mat[4]),
      .rsp_out_r1c2 (rsp_mat[5]),
      .rsp_out_r2c0 (rsp_mat[6]),
      .rsp_out_r2c1 (rsp_mat[7]),
      .rsp_out_r2c2 (rsp_mat[8]),
      .rsp_singular (rsp_singular),
      .rsp_overflow (rsp_overflow)
   );

   // Computes the inverse exactly in wide signed integers. A 128-bit signed
   // word holds every cofactor (65 bits), the determinant (97 bits) and the
   // cofactor shifted left by 32, so nothing wraps. SystemVerilog signed
   // division truncates toward zero, which is the rounding that is wanted.
   function automatic inverse_type invert_matrix(matrix_type mat);
      logic signed [127:0] elem [NUM_ELEMS];
      logic signed [127:0] cof [NUM_ELEMS];
      logic signed [127:0] det;
      logic signed [127:0] quot;
      inverse_type         inv;
      inv = '0;
      for (int i = 0; i < NUM_ELEMS; i++) begin
         elem[i] = $signed(mat[i]);
      end
      for (int k = 0; k < NUM_ELEMS; k++) begin
         cof[k] = elem[COF_IDX[k][0]] * elem[COF_IDX[k][1]]
                - elem[COF_IDX[k][2]] * elem[COF_IDX[k][3]];
      end
      det = elem[0] * cof[0] + elem[1] * cof[3] + elem[2] * cof[6];
      if (det == 0) begin
         // A singular matrix gives all zero elements and only the flag.
         inv.singular = 1'b1;
         return inv;
      end
      for (int k = 0; k < NUM_ELEMS; k++) begin
         quot = (cof[k] <<< (2 * FRAC_W)) / det;
         if (quot > $signed(128'(POS_MAX))) begin
            inv.elems[k] = POS_MAX;
            inv.overflow = 1'b1;
         end else if (quot < -$signed(128'(NEG_MAX))) begin
            inv.elems[k] = NEG_MAX;
            inv.overflow = 1'b1;
         end else begin
            inv.elems[k] = quot[31:0];
         end
      end
      return inv;
   endfunction

   // Every transfer into the block queues its expected inverse; every strobe
   // out of it is checked against the oldest one. Both read values from
   // before the edge, so the order of events in the time step does not matter.
   always @(posedge clock) begin
      inverse_type exp_inv;
      if (!reset) begin
         cycles <= cycles + 1;
         if (start && !busy) begin
            expected_inverses.push_back(req_typed ? req_inv : invert_matrix(req_mat));
         end
         if (rsp_valid) begin
            if (expected_inverses.size() == 0) begin
               $error("result with no matrix outstanding");
               failures++;
            end else begin
               exp_inv = expected_inverses.pop_front();
               for (int k = 0; k < NUM_ELEMS; k++) begin
                  if (rsp_mat[k] !== exp_inv.elems[k]) begin
                     $error("out_r%0dc%0d: expected %h, actual %h", k / 3, k % 3,
                            exp_inv.elems[k], rsp_mat[k]);
                     failures++;
                  end
               end
               if (rsp_singular !== exp_inv.singular) begin
                  $error("singular: expected %b, actual %b", exp_inv.singular,
                         rsp_singular);
                  failures++;
               end
               if (rsp_overflow !== exp_inv.overflow) begin
                  $error("overflow: expected %b, actual %b", exp_inv.overflow,
                         rsp_overflow);
                  failures++;
               end
            end
         end
      end
   end

   // The run ends at the cycle limit if the block hangs.
   always @(posedge clock) begin
      if (cycles >= LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic matrix_type diag_matrix(logic [31:0] v);
      matrix_type mat;
      mat = '0;
      mat[0] = v;
      mat[4] = v;
      mat[8] = v;
      return mat;
   endfunction

   function automatic inverse_type diag_inverse(logic [31:0] v, logic ovf);
      inverse_type inv;
      inv = '0;
      inv.elems[0] = v;
      inv.elems[4] = v;
      inv.elems[8] = v;
      inv.overflow = ovf;
      return inv;
   endfunction

   // Draws one element: mostly small values from -4.0 to 4.0, sometimes a shifted small value or any 32 bits.
   function automatic logic [31:0] random_elem();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom();
         2:       return $urandom_range(0, 3) << ($urandom_range(0, 31));
         default: return 32'($signed($urandom_range(0, 2 * 262144)) - 262144);
      endcase
   endfunction

   function automatic matrix_type random_matrix();
      matrix_type mat;
      int         kind;
      for (int i = 0; i < NUM_ELEMS; i++) begin
         mat[i] = random_elem();
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         // A repeated row makes the determinant exactly zero.
         mat[6] = mat[0];
         mat[7] = mat[1];
         mat[8] = mat[2];
      end else if (kind == 1) begin
         // A zero column is singular as well.
         mat[1] = '0;
         mat[4] = '0;
         mat[7] = '0;
      end else if (kind == 2) begin
         // Upper triangular with a tiny diagonal drives the quotients to saturation.
         mat[3] = '0;
         mat[6] = '0;
         mat[7] = '0;
         mat[$urandom_range(0, 2) * 4] = $urandom_range(1, 16);
      end
      return mat;
   endfunction

   // Offers one matrix and holds it until the block takes it. The start line
   // stays high for the next matrix unless a random gap follows.
   task automatic send_matrix(matrix_type mat, logic typed, inverse_type inv, bit may_idle);
      req_mat   <= mat;
      req_typed <= typed;
      req_inv   <= inv;
      start     <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      if (may_idle && $urandom_range(0, 99) < 17) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   stim_row_type directed_rows[$];

   initial begin
      matrix_type neg_mat;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Typed rows: identity, scaling, zero and extreme matrices, saturation.
      directed_rows.push_back('{diag_matrix(ONE), 1'b1, diag_inverse(ONE, 1'b0)});
      directed_rows.push_back('{diag_matrix(32'h0002_0000), 1'b1,
                                diag_inverse(32'h0000_8000, 1'b0)});
      directed_rows.push_back('{diag_matrix(-ONE), 1'b1, diag_inverse(-ONE, 1'b0)});
      directed_rows.push_back('{'0, 1'b1, '{elems: '0, singular: 1'b1, overflow: 1'b0}});
      directed_rows.push_back('{{NUM_ELEMS{POS_MAX}}, 1'b1,
                                '{elems: '0, singular: 1'b1, overflow: 1'b0}});
      directed_rows.push_back('{{NUM_ELEMS{NEG_MAX}}, 1'b1,
                                '{elems: '0, singular: 1'b1, overflow: 1'b0}});
      directed_rows.push_back('{{NUM_ELEMS{32'hffff_ffff}}, 1'b1,
                                '{elems: '0, singular: 1'b1, overflow: 1'b0}});
      // The smallest positive diagonal overflows high, the negative one low.
      directed_rows.push_back('{diag_matrix(32'h1), 1'b1, diag_inverse(POS_MAX, 1'b1)});
      directed_rows.push_back('{diag_matrix(32'hffff_ffff), 1'b1,
                                diag_inverse(NEG_MAX, 1'b1)});
      // The rest are checked against the predictor.
      directed_rows.push_back('{diag_matrix(POS_MAX), 1'b0, '0});
      directed_rows.push_back('{diag_matrix(NEG_MAX), 1'b0, '0});
      neg_mat = diag_matrix(NEG_MAX);
      neg_mat[1] = POS_MAX;
      neg_mat[5] = 32'h1;
      neg_mat[6] = NEG_MAX;
      directed_rows.push_back('{neg_mat, 1'b0, '0});
      directed_rows.push_back('{{32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                 32'h0000_0000, 32'h0001_0000, 32'h0004_0000,
                                 32'h0005_0000, 32'h0006_0000, 32'h0000_0000},
                                1'b0, '0});
      directed_rows.push_back('{{32'h0003_0000, 32'hffff_0000, 32'h0000_8000,
                                 32'h0000_0001, 32'h0007_0000, 32'hfffe_0000,
                                 32'h1234_5678, 32'hedcb_a988, 32'h0000_3000},
                                1'b0, '0});
      directed_rows.push_back('{{NUM_ELEMS{32'h5555_5555}}, 1'b0, '0});
      directed_rows.push_back('{{32'haaaa_aaaa, 32'h0, 32'h0, 32'h0, 32'h5555_5555,
                                 32'h0, 32'h0, 32'h0, 32'haaaa_aaaa}, 1'b0, '0});

      foreach (directed_rows[r]) begin
         send_matrix(directed_rows[r].mat, directed_rows[r].typed,
                     directed_rows[r].inv, 1'b1);
      end

      // Random part. Items 300 to 599 go back to back with no gaps,
      // and once the sender waits until the block has drained completely.
      for (int n = 0; n < ITEMS; n++) begin
         if (n == ITEMS / 2) begin
            start <= 1'b0;
            @(posedge clock);
            while (expected_inverses.size() != 0) begin
               @(posedge clock);
            end
         end
         send_matrix(random_matrix(), 1'b0, '0, !(n >= 300 && n < 600));
      end
      start <= 1'b0;

      while (expected_inverses.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN) @(posedge clock);

      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
